/* src/cxi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cxi_pkg - shared types, constants and matching-function ROM
// Widths, band limits, divide-by-five reciprocals and the 81-entry table of
// X, Y, Z color matching values (unsigned Q1.14, 380 nm to 780 nm, 5 nm step).
// ============================================================================
package cxi_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 81;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CHANNELS      = 3;
    localparam int RAW_W         = 15;
    localparam int ROM_W         = 15;

    // Field widths
    localparam int WL_W   = 16;
    localparam int GAIN_W = 24;
    localparam int OUT_W  = 32;
    localparam int OFF_W  = 13;
    localparam int FRAC_W = 7;

    // Band limits and interval size, all in Q4 nanometres
    localparam logic [WL_W-1:0]   BAND_LO_Q4 = 16'd6080;
    localparam logic [WL_W-1:0]   BAND_HI_Q4 = 16'd12480;
    localparam logic [FRAC_W-1:0] STEP_Q4    = 7'd80;

    // Interval index = (offset >> 4) / 5 through a reciprocal
    localparam int COARSE_W     = OFF_W - 4;
    localparam int IDX_MUL_W    = 8;
    localparam int IDX_PROD_W   = COARSE_W + IDX_MUL_W;
    localparam logic [IDX_MUL_W-1:0] IDX_MUL = 8'd205;
    localparam int IDX_SHIFT    = 10;

    // Gain register reset (1.0 in Q8.16)
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

    // Datapath widths of the back end
    localparam int INTERP_W    = 22;
    localparam int PROD_W      = INTERP_W + GAIN_W;
    localparam logic [PROD_W-1:0] ROUND_BIAS = 46'd10240;
    localparam int ROUND_SHIFT = 12;
    localparam int SHIFT_W     = PROD_W - ROUND_SHIFT;

    // Divide by five in two chunks: high chunk, then remainder and low chunk
    localparam int LO_W        = 17;
    localparam int HI_W        = SHIFT_W - LO_W;
    localparam int QH_W        = OUT_W - LO_W;
    localparam int REM_W       = 3;
    localparam int U_W         = REM_W + LO_W;
    localparam int DIV5_HI_MW  = 16;
    localparam logic [DIV5_HI_MW-1:0] DIV5_HI_MUL = 16'd52429;
    localparam int DIV5_HI_SH  = 18;
    localparam int DIV5_LO_MW  = 20;
    localparam logic [DIV5_LO_MW-1:0] DIV5_LO_MUL = 20'd838861;
    localparam int DIV5_LO_SH  = 22;

    // Back-end stage count
    localparam int STAGES = 5;

    // Queue depth default
    localparam int QUEUE_DEPTH_DEF = 2;

    // One classified transaction between front and back
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [FRAC_W-1:0] frac;
        logic              in_band;
    } t_item;

    typedef logic [CHANNELS-1:0][RAW_W-1:0] t_raw_row;
    typedef logic [TABLE_ENTRIES-1:0][CHANNELS-1:0][ROM_W-1:0] t_rom;

    function automatic t_raw_row row3(input int unsigned x, input int unsigned y,
                                      input int unsigned z);
        t_raw_row r;
        r[0] = RAW_W'(x);
        r[1] = RAW_W'(y);
        r[2] = RAW_W'(z);
        return r;
    endfunction

    // Tabulated values in ten-thousandths
    function automatic t_raw_row cmf_raw(input logic [IDX_W-1:0] e);
        t_raw_row r;
        case (e)
            7'd0:  r = row3(14, 0, 65);
            7'd1:  r = row3(22, 1, 105);
            7'd2:  r = row3(42, 1, 201);
            7'd3:  r = row3(76, 2, 362);
            7'd4:  r = row3(143, 4, 679);
            7'd5:  r = row3(232, 6, 1102);
            7'd6:  r = row3(435, 12, 2074);
            7'd7:  r = row3(776, 22, 3713);
            7'd8:  r = row3(1344, 40, 6456);
            7'd9:  r = row3(2148, 73, 10391);
            7'd10: r = row3(2839, 116, 13856);
            7'd11: r = row3(3285, 168, 16230);
            7'd12: r = row3(3483, 230, 17471);
            7'd13: r = row3(3481, 298, 17826);
            7'd14: r = row3(3362, 380, 17721);
            7'd15: r = row3(3187, 480, 17441);
            7'd16: r = row3(2908, 600, 16692);
            7'd17: r = row3(2511, 739, 15281);
            7'd18: r = row3(1954, 910, 12876);
            7'd19: r = row3(1421, 1126, 10419);
            7'd20: r = row3(956, 1390, 8130);
            7'd21: r = row3(580, 1693, 6162);
            7'd22: r = row3(320, 2080, 4652);
            7'd23: r = row3(147, 2586, 3533);
            7'd24: r = row3(49, 3230, 2720);
            7'd25: r = row3(24, 4073, 2123);
            7'd26: r = row3(93, 5030, 1582);
            7'd27: r = row3(291, 6082, 1117);
            7'd28: r = row3(633, 7100, 782);
            7'd29: r = row3(1096, 7932, 573);
            7'd30: r = row3(1655, 8620, 422);
            7'd31: r = row3(2257, 9149, 298);
            7'd32: r = row3(2904, 9540, 203);
            7'd33: r = row3(3597, 9803, 134);
            7'd34: r = row3(4334, 9950, 87);
            7'd35: r = row3(5121, 10000, 57);
            7'd36: r = row3(5945, 9950, 39);
            7'd37: r = row3(6784, 9786, 27);
            7'd38: r = row3(7621, 9520, 21);
            7'd39: r = row3(8425, 9154, 18);
            7'd40: r = row3(9163, 8700, 17);
            7'd41: r = row3(9786, 8163, 14);
            7'd42: r = row3(10263, 7570, 11);
            7'd43: r = row3(10567, 6949, 10);
            7'd44: r = row3(10622, 6310, 8);
            7'd45: r = row3(10456, 5668, 6);
            7'd46: r = row3(10026, 5030, 3);
            7'd47: r = row3(9384, 4412, 2);
            7'd48: r = row3(8544, 3810, 2);
            7'd49: r = row3(7514, 3210, 1);
            7'd50: r = row3(6424, 2650, 0);
            7'd51: r = row3(5419, 2170, 0);
            7'd52: r = row3(4479, 1750, 0);
            7'd53: r = row3(3608, 1382, 0);
            7'd54: r = row3(2835, 1070, 0);
            7'd55: r = row3(2187, 816, 0);
            7'd56: r = row3(1649, 610, 0);
            7'd57: r = row3(1212, 446, 0);
            7'd58: r = row3(874, 320, 0);
            7'd59: r = row3(636, 232, 0);
            7'd60: r = row3(468, 170, 0);
            7'd61: r = row3(329, 119, 0);
            7'd62: r = row3(227, 82, 0);
            7'd63: r = row3(158, 57, 0);
            7'd64: r = row3(114, 41, 0);
            7'd65: r = row3(81, 29, 0);
            7'd66: r = row3(58, 21, 0);
            7'd67: r = row3(41, 15, 0);
            7'd68: r = row3(29, 10, 0);
            7'd69: r = row3(20, 7, 0);
            7'd70: r = row3(14, 5, 0);
            7'd71: r = row3(10, 4, 0);
            7'd72: r = row3(7, 2, 0);
            7'd73: r = row3(5, 2, 0);
            7'd74: r = row3(3, 1, 0);
            7'd75: r = row3(2, 1, 0);
            7'd76: r = row3(2, 1, 0);
            7'd77: r = row3(1, 0, 0);
            7'd78: r = row3(1, 0, 0);
            7'd79: r = row3(1, 0, 0);
            7'd80: r = row3(0, 0, 0);
            default: r = row3(0, 0, 0);
        endcase
        return r;
    endfunction

    // Convert ten-thousandths to Q1.14, rounded to nearest (elaboration only)
    function automatic t_rom build_rom();
        t_rom     rom;
        t_raw_row raw;
        int unsigned k;
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
            raw = cmf_raw(IDX_W'(e));
            for (int c = 0; c < CHANNELS; c++) begin
                k = int'(raw[c]);
                rom[e][c] = ROM_W'((k * 16384 + 5000) / 10000);
            end
        end
        return rom;
    endfunction

    localparam t_rom CMF_ROM = build_rom();

endpackage
`default_nettype wire

/* src/cie_xyz_interpolator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cie_xyz_interpolator - CIE 1931 2-degree color matching interpolator
// Wavelength in, gain-scaled X, Y, Z matching values out.
// ============================================================================
// One wavelength transaction (unsigned Q12.4 nm) is accepted per clock
// while o_stall is low and yields one X, Y, Z transaction in unsigned Q10.22,
// linearly interpolated from the built-in 5 nm table and scaled by the Q8.16
// gain register; inputs outside 380 nm up to below 780 nm give zeros with
// in_band low. Throughput is one transaction per cycle when nothing stalls.
// The accepting edge writes the input queue, and the next edge pops it into
// the first of the five back-end stages (interpolate, gain multiply, round,
// two divide-by-five steps) when nothing stalls. The input stall rises only
// when the queue of QUEUE_DEPTH entries is full, so output back-pressure
// reaches the input after the pipeline and queue fill.
// Write the gain only while no transaction is in flight.
// ============================================================================
module cie_xyz_interpolator #(
    parameter int QUEUE_DEPTH = cxi_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [cxi_pkg::WL_W-1:0]   i_wavelength_q4,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [cxi_pkg::GAIN_W-1:0] i_cfg_wr_data,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [cxi_pkg::OUT_W-1:0]       o_x_value,
    output logic [cxi_pkg::OUT_W-1:0]       o_y_value,
    output logic [cxi_pkg::OUT_W-1:0]       o_z_value,
    output logic                            o_in_band
);
    import cxi_pkg::*;

    logic [GAIN_W-1:0] r_gain;
    t_item             front_item;
    t_item             q_item;
    logic              q_full;
    logic              q_valid;
    logic              pop;

    // Hold normalization gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_gain <= i_cfg_wr_data;
        end
    end

    // Classify incoming wavelength
    cxi_front u_front (
        .i_wavelength_q4 (i_wavelength_q4),
        .o_item          (front_item)
    );

    // Queue classified transactions
    cxi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    assign o_stall = q_full;

    // Interpolate and scale
    cxi_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (pop),
        .i_gain    (r_gain),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_x_value (o_x_value),
        .o_y_value (o_y_value),
        .o_z_value (o_z_value),
        .o_in_band (o_in_band)
    );

endmodule
`default_nettype wire

/* src/cxi_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cxi_front - band check and interval split
// Classifies a wavelength as in or out of band and splits its offset from
// 380 nm into a 5 nm interval index and a fraction in 1/80 of the interval.
// ============================================================================
module cxi_front (
    input  wire logic [cxi_pkg::WL_W-1:0] i_wavelength_q4,
    output cxi_pkg::t_item                o_item
);
    import cxi_pkg::*;

    logic                  band;
    logic [WL_W-1:0]       off_full;
    logic [OFF_W-1:0]      off;
    logic [COARSE_W-1:0]   coarse;
    logic [IDX_PROD_W-1:0] idx_prod;
    logic [IDX_W-1:0]      idx;
    logic [OFF_W-1:0]      idx_x80;
    logic [OFF_W-1:0]      frac_full;

    // Check band limits
    assign band     = (i_wavelength_q4 >= BAND_LO_Q4) && (i_wavelength_q4 < BAND_HI_Q4);
    assign off_full = i_wavelength_q4 - BAND_LO_Q4;
    assign off      = off_full[OFF_W-1:0];

    // Divide offset by 80: drop four bits, then divide by five via reciprocal
    assign coarse   = off[OFF_W-1:4];
    assign idx_prod = IDX_PROD_W'(coarse) * IDX_PROD_W'(IDX_MUL);
    assign idx      = idx_prod[IDX_SHIFT +: IDX_W];

    // Remainder: offset minus index times 80 (64 + 16)
    assign idx_x80   = (OFF_W'(idx) << 6) + (OFF_W'(idx) << 4);
    assign frac_full = off - idx_x80;

    // Force index and fraction to zero out of band so the table stays in range
    always_comb begin
        o_item.in_band = band;
        o_item.idx     = band ? idx : '0;
        o_item.frac    = band ? frac_full[FRAC_W-1:0] : '0;
    end

endmodule
`default_nettype wire

/* src/cxi_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cxi_queue - transaction queue between front and back
// Small register FIFO of classified transactions; full drives input stall.
// ============================================================================
module cxi_queue #(
    parameter int DEPTH = cxi_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  cxi_pkg::t_item i_item,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_valid,
    output cxi_pkg::t_item o_item
);
    import cxi_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Track fill level
    always_comb begin
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    // Store entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

/* src/cxi_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cxi_back - interpolation and gain pipeline
// Five stages: table lookup and interpolation, gain multiply, rounding shift,
// high divide-by-five chunk, low chunk into the output register.
// ============================================================================
module cxi_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_valid,
    input  cxi_pkg::t_item                  i_item,
    output logic                            o_pop,
    input  wire logic [cxi_pkg::GAIN_W-1:0] i_gain,
    input  wire logic                       i_stall,
    output logic                            o_valid,
    output logic [cxi_pkg::OUT_W-1:0]       o_x_value,
    output logic [cxi_pkg::OUT_W-1:0]       o_y_value,
    output logic [cxi_pkg::OUT_W-1:0]       o_z_value,
    output logic                            o_in_band
);
    import cxi_pkg::*;

    // Stage control
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] r_band;
    logic [STAGES-1:0] rdy;

    // Stage payloads
    logic [INTERP_W-1:0] r_n   [CHANNELS];
    logic [PROD_W-1:0]   r_p   [CHANNELS];
    logic [SHIFT_W-1:0]  r_t   [CHANNELS];
    logic [QH_W-1:0]     r_qh  [CHANNELS];
    logic [HI_W-1:0]     r_th  [CHANNELS];
    logic [LO_W-1:0]     r_tl  [CHANNELS];
    logic [OUT_W-1:0]    r_out [CHANNELS];

    // Next values
    logic [INTERP_W-1:0]          n_n    [CHANNELS];
    logic [PROD_W-1:0]            n_p    [CHANNELS];
    logic [SHIFT_W-1:0]           n_t    [CHANNELS];
    logic [QH_W-1:0]              n_qh   [CHANNELS];
    logic [OUT_W-1:0]             n_out  [CHANNELS];
    logic [PROD_W-1:0]            rnd    [CHANNELS];
    logic [HI_W+DIV5_HI_MW-1:0]   prod_h [CHANNELS];
    logic [HI_W-1:0]              qh5    [CHANNELS];
    logic [HI_W-1:0]              rem_w  [CHANNELS];
    logic [U_W-1:0]               u      [CHANNELS];
    logic [U_W+DIV5_LO_MW-1:0]    prod_l [CHANNELS];
    logic [ROM_W-1:0]             ent_a  [CHANNELS];
    logic [ROM_W-1:0]             ent_b  [CHANNELS];
    logic [FRAC_W-1:0]            wt_a;
    logic [IDX_W-1:0]             idx_b;

    // Ready chain from the output register back to the queue
    always_comb begin
        rdy[STAGES-1] = !r_vld[STAGES-1] || !i_stall;
        for (int s = STAGES - 2; s >= 0; s--) begin
            rdy[s] = !r_vld[s] || rdy[s+1];
        end
    end

    assign o_pop = i_q_valid && rdy[0];

    // Stage 1: look up both interval ends and blend
    assign wt_a  = STEP_Q4 - i_item.frac;
    assign idx_b = i_item.idx + IDX_W'(1);

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            ent_a[c] = CMF_ROM[i_item.idx][c];
            ent_b[c] = CMF_ROM[idx_b][c];
            n_n[c]   = i_item.in_band
                     ? (INTERP_W'(ent_a[c]) * INTERP_W'(wt_a))
                       + (INTERP_W'(ent_b[c]) * INTERP_W'(i_item.frac))
                     : '0;
        end
    end

    // Stage 2: apply gain; stage 3: round and drop 12 bits
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_p[c] = PROD_W'(r_n[c]) * PROD_W'(i_gain);
            // The product stays far below the top of PROD_W, so the bias cannot carry out
            rnd[c] = r_p[c] + ROUND_BIAS;
            n_t[c] = rnd[c][PROD_W-1:ROUND_SHIFT];
        end
    end

    // Stage 4: divide the high chunk by five
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            prod_h[c] = (HI_W + DIV5_HI_MW)'(r_t[c][SHIFT_W-1:LO_W])
                      * (HI_W + DIV5_HI_MW)'(DIV5_HI_MUL);
            n_qh[c]   = prod_h[c][DIV5_HI_SH +: QH_W];
        end
    end

    // Stage 5: carry the remainder into the low chunk and divide it by five.
    // The quotient is below 2^32 for every gain, so the Q10.22 ceiling is never hit.
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            qh5[c]    = (HI_W'(r_qh[c]) << 2) + HI_W'(r_qh[c]);
            rem_w[c]  = r_th[c] - qh5[c];
            u[c]      = {rem_w[c][REM_W-1:0], r_tl[c]};
            prod_l[c] = (U_W + DIV5_LO_MW)'(u[c]) * (U_W + DIV5_LO_MW)'(DIV5_LO_MUL);
            n_out[c]  = {r_qh[c], prod_l[c][DIV5_LO_SH +: LO_W]};
        end
    end

    // Advance valid and band flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_q_valid;
            end
            for (int s = 1; s < STAGES; s++) begin
                if (rdy[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Load payloads
    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_q_valid) begin
            r_band[0] <= i_item.in_band;
            r_n       <= n_n;
        end
        if (rdy[1] && r_vld[0]) begin
            r_band[1] <= r_band[0];
            r_p       <= n_p;
        end
        if (rdy[2] && r_vld[1]) begin
            r_band[2] <= r_band[1];
            r_t       <= n_t;
        end
        if (rdy[3] && r_vld[2]) begin
            r_band[3] <= r_band[2];
            r_qh      <= n_qh;
            for (int c = 0; c < CHANNELS; c++) begin
                r_th[c] <= r_t[c][SHIFT_W-1:LO_W];
                r_tl[c] <= r_t[c][LO_W-1:0];
            end
        end
        if (rdy[4] && r_vld[3]) begin
            r_band[4] <= r_band[3];
            r_out     <= n_out;
        end
    end

    assign o_valid   = r_vld[STAGES-1];
    assign o_in_band = r_band[STAGES-1];
    assign o_x_value = r_out[0];
    assign o_y_value = r_out[1];
    assign o_z_value = r_out[2];

endmodule
`default_nettype wire

/* src/cxi_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cxi_checker - port-level checks for the interpolator
// Watches the top-level ports over time; attached by bind.
// ============================================================================
module cxi_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       o_stall,
    input wire logic [cxi_pkg::WL_W-1:0]   i_wavelength_q4,
    input wire logic                       i_cfg_wr_en,
    input wire logic [cxi_pkg::GAIN_W-1:0] i_cfg_wr_data,
    input wire logic                       o_valid,
    input wire logic                       i_stall,
    input wire logic [cxi_pkg::OUT_W-1:0]  o_x_value,
    input wire logic [cxi_pkg::OUT_W-1:0]  o_y_value,
    input wire logic [cxi_pkg::OUT_W-1:0]  o_z_value,
    input wire logic                       o_in_band
);
    import cxi_pkg::*;

    // Reset empties the pipeline and the queue
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output valid or input stall set after reset");

    // Out-of-band transaction carries zeros
    a_band_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_band) |->
            (o_x_value == '0 && o_y_value == '0 && o_z_value == '0))
        else $error("nonzero value on out-of-band transaction");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_x_value) && $stable(o_y_value)
             && $stable(o_z_value) && $stable(o_in_band)))
        else $error("stalled output transaction changed");

    // Nothing reaches the output without an earlier input transaction
    a_no_early_out: assert property (@(posedge i_clk)
        !i_rst_n ##1 !i_valid |=> !o_valid)
        else $error("output valid without any accepted input");

endmodule

bind cie_xyz_interpolator cxi_checker u_cxi_checker (.*);
`default_nettype wire
